// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_REM_TAIL = 3'd2,
    OP_REM_AT   = 3'd3,
    OP_REM_HEAD = 3'd4,
    OP_READ     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_value;
    logic [WORD_W-1:0]   head_value;
    logic [WORD_W-1:0]   tail_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } ple_out_t;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine: a bounded ordered list of data words.
// Input channel: in_item carries operation, position and value. A transaction
// is taken at a rising edge with start high and busy low. busy is low in every
// cycle after the first cycle that follows reset, so one transaction can be
// taken each cycle.
// Result channel: out_valid is high for exactly one cycle, the cycle right
// after the input transaction, and out_item then holds status, the word read,
// head and tail words, count and the empty flag after the operation.
// Throughput is one transaction per cycle; each operation is a single parallel
// shift of the register array set by the index compare on every entry plus
// one read mux.
// Reset clears the element count and drops any pending result; stored words
// are not cleared and are never shown before they are written.
// The receiver cannot stall: a result that is not taken in its cycle is gone.
// CAPACITY sets the number of entries, DATA_WIDTH the width kept per entry;
// values are truncated to DATA_WIDTH and zero-extended back on the outputs.
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ple_pkg::ple_in_t  in_item,
  output logic              busy,
  output logic              out_valid,
  output ple_pkg::ple_out_t out_item
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = LW + ple_pkg::POS_W;

  logic [DATA_WIDTH-1:0] cells_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [LW-1:0]         length_r;
  logic [LW-1:0]         length_nxt;
  logic                  busy_r;
  logic                  out_valid_r;
  ple_pkg::ple_out_t     out_r;
  ple_pkg::ple_out_t     out_nxt;

  logic                  acc;
  logic                  full;
  logic                  empty;
  logic                  do_ins;
  logic                  do_rem;
  logic                  rem_tail;
  logic [LW-1:0]         ins_at;
  logic [LW-1:0]         rem_at;
  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         len_c;
  logic [IW-1:0]         pos_idx;
  logic [IW-1:0]         tail_idx;
  logic [IW-1:0]         prev_idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_cell;
  logic [DATA_WIDTH-1:0] tail_cell;
  logic [DATA_WIDTH-1:0] prev_cell;
  logic [DATA_WIDTH-1:0] tail_new;
  logic [DATA_WIDTH-1:0] rd_data;
  ple_pkg::status_e      status;

  assign acc       = start & ~busy_r;
  assign full      = (length_r == LW'(CAPACITY));
  assign empty     = (length_r == '0);
  assign pos_c     = CW'(in_item.position);
  assign len_c     = CW'(length_r);
  assign pos_idx   = IW'(in_item.position);
  assign tail_idx  = IW'(length_r - LW'(1));
  assign prev_idx  = IW'(length_r - LW'(2));
  assign wr_data   = DATA_WIDTH'(in_item.value);
  assign rd_cell   = cells_r[pos_idx];
  assign tail_cell = cells_r[tail_idx];
  assign prev_cell = cells_r[prev_idx];
  assign rem_tail  = (rem_at == length_r - LW'(1));

  always_comb begin
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    ins_at  = length_r;
    rem_at  = length_r - LW'(1);
    status  = ple_pkg::ST_OK;
    rd_data = '0;
    case (in_item.operation)
      ple_pkg::OP_APPEND: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ple_pkg::OP_INSERT: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          if (pos_c < len_c) begin
            ins_at = LW'(in_item.position);
          end
        end
      end
      ple_pkg::OP_REM_TAIL: begin
        if (empty) begin
          status = ple_pkg::ST_NONE;
        end else begin
          do_rem = 1'b1;
        end
      end
      ple_pkg::OP_REM_AT: begin
        if (empty) begin
          status = ple_pkg::ST_NONE;
        end else begin
          do_rem = 1'b1;
          if (pos_c < len_c - CW'(1)) begin
            rem_at = LW'(in_item.position);
          end
        end
      end
      ple_pkg::OP_REM_HEAD: begin
        if (empty) begin
          status = ple_pkg::ST_NONE;
        end else begin
          do_rem = 1'b1;
          rem_at = '0;
        end
      end
      ple_pkg::OP_READ: begin
        if (pos_c < len_c) begin
          rd_data = rd_cell;
        end else begin
          status = ple_pkg::ST_NONE;
        end
      end
      default: begin
        status = ple_pkg::ST_NONE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [LW-1:0] IDX = LW'(i);
    logic [DATA_WIDTH-1:0] below_cell;
    logic [DATA_WIDTH-1:0] above_cell;

    if (i > 0) begin : g_below
      assign below_cell = cells_r[i-1];
    end else begin : g_first
      assign below_cell = cells_r[i];
    end

    if (i < CAPACITY - 1) begin : g_above
      assign above_cell = cells_r[i+1];
    end else begin : g_last
      assign above_cell = cells_r[i];
    end

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (IDX == ins_at) begin
          cells_nxt[i] = wr_data;
        end else if (IDX > ins_at) begin
          cells_nxt[i] = below_cell;
        end
      end else if (do_rem && (IDX >= rem_at) && (IDX < length_r - LW'(1))) begin
        cells_nxt[i] = above_cell;
      end
    end
  end

  always_comb begin
    if (do_ins) begin
      length_nxt = length_r + LW'(1);
      tail_new   = (ins_at == length_r) ? wr_data : tail_cell;
    end else if (do_rem) begin
      length_nxt = length_r - LW'(1);
      tail_new   = rem_tail ? prev_cell : tail_cell;
    end else begin
      length_nxt = length_r;
      tail_new   = tail_cell;
    end
  end

  always_comb begin
    out_nxt.status     = status;
    out_nxt.read_value = ple_pkg::WORD_W'(rd_data);
    out_nxt.head_value = (length_nxt == '0) ? '0 : ple_pkg::WORD_W'(cells_nxt[0]);
    out_nxt.tail_value = (length_nxt == '0) ? '0 : ple_pkg::WORD_W'(tail_new);
    out_nxt.count      = ple_pkg::COUNT_W'(length_nxt);
    out_nxt.is_empty   = (length_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= acc;
      if (acc) begin
        length_r <= length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cells_r <= cells_nxt;
      out_r   <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted transaction");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= LW'(CAPACITY))
    else $error("element count beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (length_r == '0)))
    else $error("empty flag disagrees with element count");

  a_failed_op_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ple_pkg::ST_OK)) |-> $stable(length_r))
    else $error("failed operation changed the element count");

endmodule

// ===== sim/positional_list_engine_test.sv =====
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1620;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_GAP      = 17;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  typedef struct {
    ple_in_t item;
    int      gap;
  } queued_op_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  ple_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  ple_out_t out_item;

  queued_op_t op_backlog[$];
  ple_out_t   predicted_reports[$];

  logic [WORD_W-1:0] list_words [LIST_DEPTH];
  int list_len = 0;
  int idle_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ple_out_t list_apply(ple_in_t t);
    ple_out_t r;
    int slot;
    r = '0;
    r.status = ST_OK;
    case (t.operation)
      OP_APPEND, OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = (t.operation == OP_APPEND || t.position >= list_len) ? list_len
                                                                      : t.position;
          for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = t.value;
          list_len++;
        end
      end
      OP_REM_TAIL, OP_REM_AT, OP_REM_HEAD: begin
        if (list_len == 0) begin
          r.status = ST_NONE;
        end else begin
          if (t.operation == OP_REM_HEAD) slot = 0;
          else if (t.operation == OP_REM_AT && t.position < list_len - 1) slot = t.position;
          else slot = list_len - 1;
          for (int i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (t.position < list_len) r.read_value = list_words[t.position];
        else r.status = ST_NONE;
      end
      default: r.status = ST_NONE;
    endcase
    r.head_value = (list_len != 0) ? list_words[0] : '0;
    r.tail_value = (list_len != 0) ? list_words[list_len-1] : '0;
    r.count      = list_len[COUNT_W-1:0];
    r.is_empty   = (list_len == 0);
    return r;
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] word, int gap);
    queued_op_t q;
    q.item.operation = op;
    q.item.position  = pos;
    q.item.value     = word;
    q.gap            = gap;
    op_backlog.push_back(q);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int mode);
    int roll;
    int grow;
    roll = $urandom_range(0, 99);
    grow = (mode == MODE_GROW) ? 70 : (mode == MODE_SHRINK) ? 25 : 48;
    if (roll < 3) return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    if (roll < 3 + grow) return ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
    if (roll < 15 + grow) return OP_READ;
    case ($urandom_range(0, 2))
      0: return OP_REM_TAIL;
      1: return OP_REM_AT;
      default: return OP_REM_HEAD;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return $urandom;
  endfunction

  task automatic check_field(string field, logic [WORD_W-1:0] want,
                             logic [WORD_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
    end
  endtask

  // driver: present one transaction at a time, idle the gap drawn for the next one before it
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) predicted_reports.push_back(list_apply(in_item));
      if (start && busy) begin
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        in_item <= op_backlog[0].item;
        start <= 1'b1;
        void'(op_backlog.pop_front());
        idle_left = (op_backlog.size() != 0) ? op_backlog[0].gap : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ple_out_t want;
    if (rst_n && out_valid) begin
      if (predicted_reports.size() == 0) begin
        fail_count++;
        $display("%0t unexpected transaction: expected none actual %h", $time, out_item);
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("read_value", want.read_value, out_item.read_value);
        check_field("head_value", want.head_value, out_item.head_value);
        check_field("tail_value", want.tail_value, out_item.tail_value);
        check_field("count", want.count, out_item.count);
        check_field("is_empty", want.is_empty, out_item.is_empty);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int made;
    int mode;
    int phase_len;
    bit burst;

    queue_op(OP_REM_TAIL, 4'd0, '0, 0);
    queue_op(OP_REM_AT, 4'd0, '0, 0);
    queue_op(OP_REM_HEAD, 4'd0, '0, 0);
    queue_op(OP_READ, 4'd0, '0, 0);
    queue_op(OP_SPARE_LO, 4'd0, '1, 0);
    queue_op(OP_SPARE_HI, 4'd15, '1, 0);
    queue_op(OP_APPEND, 4'd0, '0, 0);
    queue_op(OP_APPEND, 4'd15, '1, 0);
    queue_op(OP_INSERT, 4'd0, 32'h1234_5678, 0);
    queue_op(OP_INSERT, 4'd15, 32'h8000_0001, 0);
    queue_op(OP_INSERT, 4'd1, 32'h5a5a_a5a5, 0);
    for (int i = 0; i < LIST_DEPTH - 5; i++) queue_op(OP_APPEND, 4'd0, $urandom, 0);
    queue_op(OP_APPEND, 4'd0, 32'hdead_beef, 0);
    queue_op(OP_INSERT, 4'd3, 32'hcafe_f00d, 0);
    queue_op(OP_READ, 4'd15, '0, 0);
    queue_op(OP_READ, 4'd0, '0, 0);
    queue_op(OP_REM_AT, 4'd15, '0, 0);
    queue_op(OP_REM_AT, 4'd0, '0, 0);
    queue_op(OP_REM_AT, 4'd7, '0, 0);
    queue_op(OP_REM_HEAD, 4'd0, '0, 0);
    queue_op(OP_REM_TAIL, 4'd0, '0, 0);
    queue_op(OP_READ, 4'd15, '0, 0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_GROW, MODE_MIX);
      burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 80);
      for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
        queue_op(pick_op(mode), POS_W'($urandom_range(0, 15)), pick_word(),
                 burst ? 0 : $urandom_range(0, MAX_GAP));
        made++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (op_backlog.size() != 0 || start || predicted_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ple_pkg.sv
rtl/core/positional_list_engine.sv
sim/positional_list_engine_test.sv
